// File: rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg: shared definitions for the piecewise linear lookup unit
// Widths, request codes, table entry layout and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int SPEED_W  = 8;
  localparam int OFF_W    = 8;
  localparam int INDEX_W  = 6;
  localparam int CNT_W    = 7;
  localparam int MUL_W    = 9;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int NUMS_W   = 20;
  localparam int NUM_W    = 18;
  localparam int DEN_W    = 9;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [OFF_W-1:0]   offset;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/piecewise_linear_lookup_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_lookup_unit: breakpoint table with interpolated lookup
// A write transfer goes straight into the table; a lookup checks the first and
// last points, then scans the table one entry per cycle and, between breakpoints,
// multiplies and runs the serial divider; a stalled earlier result holds the output.
// One item is in work at a time; the next transfer is taken once the result is
// in the output register. Reset clears the point count, the sequencer and the
// output valid; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_lookup_unit
  import pwl_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CNT_W-1:0]   cfg_point_count_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [INDEX_W-1:0] entry_index_i,
  input  wire logic [SPEED_W-1:0] entry_speed_i,
  input  wire logic [OFF_W-1:0]   entry_offset_i,
  input  wire logic [SPEED_W-1:0] query_speed_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [OFF_W-1:0]        offset_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_MUL1, S_MUL2, S_DSTART, S_DIV, S_OUT
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          n_eff;
  logic [CNT_W-1:0]          idx_q;
  logic signed [SPEED_W-1:0] q_q;
  logic signed [SPEED_W-1:0] prev_spd_q;
  logic signed [OFF_W-1:0]   prev_off_q;
  logic signed [SPEED_W-1:0] s2_q;
  logic signed [OFF_W-1:0]   o2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [NUMS_W-1:0]  num_q;
  logic signed [OFF_W-1:0]   res_q;
  logic                      out_valid_q;
  logic [OFF_W-1:0]          offset_q;

  logic                      in_acc;
  logic                      wr_en;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  entry_t                    wr_data;
  entry_t                    rd_data;
  logic signed [SPEED_W-1:0] rd_spd;
  logic signed [OFF_W-1:0]   rd_off;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [NUMS_W-1:0]  num_d;
  logic signed [MUL_W-1:0]   ds;
  logic                      num_neg;
  logic [NUMS_W-1:0]         num_abs;
  logic [OFF_W-1:0]          quo_lo;
  logic signed [OFF_W-1:0]   div_res;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign n_eff       = (int'(cnt_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : cnt_q;

  assign wr_en          = in_acc && (req_type_i == REQ_WRITE)
                          && (int'(entry_index_i) < TABLE_DEPTH);
  assign wr_data.speed  = entry_speed_i;
  assign wr_data.offset = entry_offset_i;
  assign rd_spd         = $signed(rd_data.speed);
  assign rd_off         = $signed(rd_data.offset);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        rd_en = in_acc && (req_type_i == REQ_LOOKUP);
      end
      S_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(n_eff - 1'b1);
      end
      S_LAST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_q + 1'b1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  pwl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(entry_index_i)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    ds = MUL_W'(s2_q) - MUL_W'(prev_spd_q);
    if (state_q == S_MUL1) begin
      mul_a = $signed({prev_off_q, 1'b1});
      mul_b = ds;
    end else begin
      mul_a = MUL_W'(o2_q) - MUL_W'(prev_off_q);
      mul_b = MUL_W'(q_q) - MUL_W'(prev_spd_q);
    end
    mul_p   = mul_a * mul_b;
    num_d   = NUMS_W'(prod_q) + (NUMS_W'(mul_p) <<< 1);
    num_neg = num_q[NUMS_W-1];
    num_abs = num_neg ? NUMS_W'(-num_q) : NUMS_W'(num_q);
    quo_lo  = div_rsp.quo[OFF_W-1:0];
    div_res = num_neg ? $signed(-quo_lo) : $signed(quo_lo);
  end

  assign div_req.start = (state_q == S_DSTART);
  assign div_req.num   = num_abs[NUM_W-1:0];
  assign div_req.den   = {ds[SPEED_W-1:0], 1'b0};

  pwl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      q_q         <= '0;
      prev_spd_q  <= '0;
      prev_off_q  <= '0;
      s2_q        <= '0;
      o2_q        <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      offset_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_q <= cfg_point_count_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (req_type_i == REQ_LOOKUP)) begin
            q_q <= $signed(query_speed_i);
            if (n_eff == '0) begin
              res_q   <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          prev_spd_q <= rd_spd;
          prev_off_q <= rd_off;
          if (n_eff == CNT_W'(1) || q_q <= rd_spd) begin
            res_q   <= rd_off;
            state_q <= S_OUT;
          end else begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          if (q_q >= rd_spd) begin
            res_q   <= rd_off;
            state_q <= S_OUT;
          end else begin
            idx_q   <= CNT_W'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (q_q >= prev_spd_q && q_q <= rd_spd) begin
            if (prev_spd_q == rd_spd) begin
              res_q   <= prev_off_q;
              state_q <= S_OUT;
            end else begin
              s2_q    <= rd_spd;
              o2_q    <= rd_off;
              state_q <= S_MUL1;
            end
          end else if (idx_q == n_eff - 1'b1) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else begin
            prev_spd_q <= rd_spd;
            prev_off_q <= rd_off;
            idx_q      <= idx_q + 1'b1;
          end
        end
        S_MUL1: begin
          prod_q  <= mul_p;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          num_q   <= num_d;
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q   <= div_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            offset_q    <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign offset_o    = offset_q;

  a_empty_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == REQ_LOOKUP) && (n_eff == '0)
      |=> (state_q == S_OUT) && (res_q == '0))
    else $error("lookup on an empty table did not give zero");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside of the divide step");

  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("sequencer waits on an idle divider");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q != '0) && (idx_q < n_eff))
    else $error("scan index left the valid point range");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("output register loaded outside of the result step");

endmodule

`default_nettype wire

// File: rtl/pwl_table.sv
// ----------------------------------------------------------------------------
// pwl_table: breakpoint storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_table
  import pwl_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire entry_t        wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output entry_t             rd_data_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/pwl_div.sv
// ----------------------------------------------------------------------------
// pwl_div: serial restoring divider
// Unsigned dividend by unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_div
  import pwl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CW = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] work_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, work_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      den_q  <= req_i.den;
      work_q <= req_i.num;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_q <= {work_q[NUM_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = work_q;

endmodule

`default_nettype wire
